// ----- design/masked_key_table_lookup_macros.svh -----
// Assertion macros shared by the key table lookup design.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef MASKED_KEY_TABLE_LOOKUP_MACROS_SVH
`define MASKED_KEY_TABLE_LOOKUP_MACROS_SVH

// cond must hold at every clock edge out of reset
`define MKTL_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define MKTL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons in the cycle after
`define MKTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/mktl_pkg.sv -----
// Package for the masked key table lookup: sizes, masks, operation codes, states.
// No dependencies.
`timescale 1ns / 1ps

package mktl_pkg;

	localparam int TABLE_DEPTH = 2048;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int WORD_W      = 32;
	localparam int SCAN_W      = 9;
	localparam int OP_W        = 2;

	localparam logic [WORD_W-1:0] KEY_MASK  = 32'hFFFF_FE00;
	localparam logic [WORD_W-1:0] SCAN_MASK = 32'h0000_01FF;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_CLEAR  = 2'd0;
	localparam op_t OP_APPEND = 2'd1;
	localparam op_t OP_LOOKUP = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_ADDR,
		ST_SRCH_CMP,
		ST_SH_RD,
		ST_SH_WR,
		ST_INSERT,
		ST_LK_RD,
		ST_LK_CHK,
		ST_FINISH
	} state_t;

endpackage

// ----- design/mktl_in_if.sv -----
// Request channel of the key table lookup: operation, entry word, lookup code.
// Depends on mktl_pkg.
`timescale 1ns / 1ps

interface mktl_in_if;
	logic                           valid;
	logic                           ready;
	logic [mktl_pkg::OP_W-1:0]      operation;
	logic [mktl_pkg::WORD_W-1:0]    entry_word;
	logic [mktl_pkg::WORD_W-1:0]    lookup_code;

	modport source (output valid, output operation, output entry_word, output lookup_code,
		input ready);
	modport sink (input valid, input operation, input entry_word, input lookup_code,
		output ready);
endinterface

// ----- design/mktl_out_if.sv -----
// Result channel of the key table lookup: found flag, scan code, overflow flag.
// Depends on mktl_pkg.
`timescale 1ns / 1ps

interface mktl_out_if;
	logic                           valid;
	logic                           ready;
	logic                           found;
	logic [mktl_pkg::SCAN_W-1:0]    scan_code;
	logic                           overflow;

	modport source (output valid, output found, output scan_code, output overflow,
		input ready);
	modport sink (input valid, input found, input scan_code, input overflow,
		output ready);
endinterface

// ----- design/mktl_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module mktl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- design/masked_key_table_lookup.sv -----
// Sorted key table with lower-bound lookup. One item at a time: ready is high only while
// the sequencer is idle. All work runs through the table RAM's single read port. A lookup
// searches for the first word not below its code, then reads that word, if there is one,
// and checks its masked key. Clear, unused codes and a dropped append go straight to the
// result. An append runs the same binary search for the first word above it, then moves
// every word above the insert point up by one, then writes the new word. An append to a
// full table is dropped with overflow set. The next item is taken while the previous
// result still waits in the output register; a finished item then waits in its last
// state until that register frees up.
`timescale 1ns / 1ps
`include "masked_key_table_lookup_macros.svh"

module masked_key_table_lookup (
	input  logic       clk,
	input  logic       arst_n,
	mktl_in_if.sink    req,
	mktl_out_if.source rsp
);

	localparam int ADDR_W = mktl_pkg::ADDR_W;
	localparam int CNT_W  = mktl_pkg::CNT_W;
	localparam int WORD_W = mktl_pkg::WORD_W;
	localparam int SCAN_W = mktl_pkg::SCAN_W;

	mktl_pkg::state_t state_q, state_d;

	mktl_pkg::op_t     op_q;
	logic [WORD_W-1:0] target_q;
	logic [CNT_W-1:0]  lo_q, hi_q, ptr_q, count_q;
	logic              res_found_q, res_ovf_q;
	logic [SCAN_W-1:0] res_scan_q;
	logic              rsp_valid_q, rsp_found_q, rsp_ovf_q;
	logic [SCAN_W-1:0] rsp_scan_q;

	logic              wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [WORD_W-1:0] wr_data, rd_data;

	logic [CNT_W-1:0]  mid, mid_p1, ptr_m1;
	logic              go_right, key_hit, accept, finish_go, table_full;

	assign mid        = lo_q + ((hi_q - lo_q) >> 1);
	assign mid_p1     = mid + CNT_W'(1);
	assign ptr_m1     = ptr_q - CNT_W'(1);
	assign table_full = (count_q >= CNT_W'(mktl_pkg::TABLE_DEPTH));
	assign accept     = req.valid && req.ready;
	assign finish_go  = (state_q == mktl_pkg::ST_FINISH) && (!rsp_valid_q || rsp.ready);

	// shared comparator: appends look for the first word above, lookups the first not below
	assign go_right = (rd_data < target_q) ||
		((op_q == mktl_pkg::OP_APPEND) && (rd_data == target_q));
	assign key_hit  = ((rd_data & mktl_pkg::KEY_MASK) == target_q);

	mktl_ram #(
		.WIDTH(WORD_W),
		.DEPTH(mktl_pkg::TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mktl_pkg::ST_IDLE: begin
				if (req.valid) begin
					case (req.operation)
						mktl_pkg::OP_APPEND:
							state_d = table_full ? mktl_pkg::ST_FINISH : mktl_pkg::ST_SRCH_ADDR;
						mktl_pkg::OP_LOOKUP: state_d = mktl_pkg::ST_SRCH_ADDR;
						default:             state_d = mktl_pkg::ST_FINISH;
					endcase
				end
			end
			mktl_pkg::ST_SRCH_ADDR: begin
				if (lo_q < hi_q) begin
					state_d = mktl_pkg::ST_SRCH_CMP;
				end else if (op_q == mktl_pkg::OP_APPEND) begin
					state_d = mktl_pkg::ST_SH_RD;
				end else begin
					state_d = mktl_pkg::ST_LK_RD;
				end
			end
			mktl_pkg::ST_SRCH_CMP: state_d = mktl_pkg::ST_SRCH_ADDR;
			mktl_pkg::ST_SH_RD: begin
				state_d = (ptr_q > lo_q) ? mktl_pkg::ST_SH_WR : mktl_pkg::ST_INSERT;
			end
			mktl_pkg::ST_SH_WR:  state_d = mktl_pkg::ST_SH_RD;
			mktl_pkg::ST_INSERT: state_d = mktl_pkg::ST_FINISH;
			mktl_pkg::ST_LK_RD: begin
				state_d = (lo_q < count_q) ? mktl_pkg::ST_LK_CHK : mktl_pkg::ST_FINISH;
			end
			mktl_pkg::ST_LK_CHK: state_d = mktl_pkg::ST_FINISH;
			mktl_pkg::ST_FINISH: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = mktl_pkg::ST_IDLE;
				end
			end
			default: state_d = mktl_pkg::ST_IDLE;
		endcase
	end

	// RAM control and handshake
	always_comb begin
		req.ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = rd_data;
		unique case (state_q)
			mktl_pkg::ST_IDLE: req.ready = 1'b1;
			mktl_pkg::ST_SRCH_ADDR: begin
				rd_en   = (lo_q < hi_q);
				rd_addr = mid[ADDR_W-1:0];
			end
			mktl_pkg::ST_SH_RD: begin
				rd_en   = (ptr_q > lo_q);
				rd_addr = ptr_m1[ADDR_W-1:0];
			end
			mktl_pkg::ST_SH_WR: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q[ADDR_W-1:0];
				wr_data = rd_data;
			end
			mktl_pkg::ST_INSERT: begin
				wr_en   = 1'b1;
				wr_addr = lo_q[ADDR_W-1:0];
				wr_data = target_q;
			end
			mktl_pkg::ST_LK_RD: begin
				rd_en   = (lo_q < count_q);
				rd_addr = lo_q[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mktl_pkg::ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (req.operation == mktl_pkg::OP_CLEAR)) begin
				count_q <= '0;
			end else if (state_q == mktl_pkg::ST_INSERT) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (finish_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= req.operation;
			target_q    <= (req.operation == mktl_pkg::OP_APPEND) ? req.entry_word
				: req.lookup_code;
			lo_q        <= '0;
			hi_q        <= count_q;
			ptr_q       <= count_q;
			res_found_q <= 1'b0;
			res_scan_q  <= '0;
			res_ovf_q   <= (req.operation == mktl_pkg::OP_APPEND) && table_full;
		end
		if (state_q == mktl_pkg::ST_SRCH_CMP) begin
			if (go_right) begin
				lo_q <= mid_p1;
			end else begin
				hi_q <= mid;
			end
		end
		if (state_q == mktl_pkg::ST_SH_WR) begin
			ptr_q <= ptr_m1;
		end
		if ((state_q == mktl_pkg::ST_LK_CHK) && key_hit) begin
			res_found_q <= 1'b1;
			res_scan_q  <= rd_data[SCAN_W-1:0];
		end
		if (finish_go) begin
			rsp_found_q <= res_found_q;
			rsp_scan_q  <= res_scan_q;
			rsp_ovf_q   <= res_ovf_q;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.found     = rsp_found_q;
	assign rsp.scan_code = rsp_scan_q;
	assign rsp.overflow  = rsp_ovf_q;

	`MKTL_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(mktl_pkg::TABLE_DEPTH), "entry count beyond table depth")
	`MKTL_ASSERT_IMPL(a_search_window, clk, arst_n, state_q == mktl_pkg::ST_SRCH_ADDR || state_q == mktl_pkg::ST_SRCH_CMP, lo_q <= hi_q && hi_q <= count_q, "search window out of range")
	`MKTL_ASSERT_NEXT(a_insert_grows, clk, arst_n, state_q == mktl_pkg::ST_INSERT, count_q == $past(count_q) + CNT_W'(1), "insert did not bump entry count")
	`MKTL_ASSERT_IMPL(a_miss_clean, clk, arst_n, rsp_valid_q && !rsp_found_q, rsp_scan_q == '0, "miss carries a scan code")

endmodule

// ----- tb/sv/masked_key_table_lookup_test.sv -----
// Self-checking bench for masked_key_table_lookup: clear, append, lookup and unused-code items
// against a sorted-table predictor, under several idling mixes and one long result back-pressure.
// Depends on mktl_pkg, mktl_in_if, mktl_out_if and the block itself.
`timescale 1ns / 1ps

module masked_key_table_lookup_test;

	localparam int WORD_W = mktl_pkg::WORD_W;
	localparam int SCAN_W = mktl_pkg::SCAN_W;

	localparam mktl_pkg::op_t OP_UNUSED = 2'd3;
	localparam int  WATCHDOG_MAX  = 20000;
	localparam int  HOLD_CYCLES   = 400;
	localparam int  RAND_PER_MODE = 277;
	localparam int  FILL_WORDS    = 300;
	localparam logic [WORD_W-1:0] DIR_KEY = 32'h1234_5600;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

	typedef struct packed {
		mktl_pkg::op_t     op;
		logic [WORD_W-1:0] word;
		logic [WORD_W-1:0] code;
	} table_req_t;

	typedef struct packed {
		logic              found;
		logic [SCAN_W-1:0] scan;
		logic              overflow;
	} lookup_result_t;

	logic clk;
	logic arst_n;

	mktl_in_if  req_ch();
	mktl_out_if rsp_ch();

	masked_key_table_lookup dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	table_req_t        item_backlog[$];
	lookup_result_t    result_due_q[$];
	logic [WORD_W-1:0] model_words[$];   // predicted table contents, ascending
	logic [WORD_W-1:0] issued_words[$];  // words appended since the last generated clear

	idle_mode_e idle_mode;
	table_req_t next_item;
	logic       req_taken;
	int         mismatches;
	int         quiet_cycles;
	int         hold_left;
	bit         hold_done;

	always #4 clk = ~clk;

	// index of the first stored word above v (past_equal) or not below v
	function automatic int model_bound(logic [WORD_W-1:0] v, bit past_equal);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = model_words.size();
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (model_words[mid] < v || (past_equal && model_words[mid] == v))
				lo = mid + 1;
			else
				hi = mid;
		end
		return lo;
	endfunction

	function automatic lookup_result_t model_table_op(table_req_t it);
		lookup_result_t r;
		int pos;
		r = '0;
		case (it.op)
			mktl_pkg::OP_CLEAR: model_words.delete();
			mktl_pkg::OP_APPEND: begin
				if (model_words.size() >= mktl_pkg::TABLE_DEPTH) begin
					r.overflow = 1'b1;
				end else begin
					pos = model_bound(it.word, 1'b1);
					if (pos == model_words.size())
						model_words = {model_words, it.word};
					else
						model_words.insert(pos, it.word);
				end
			end
			mktl_pkg::OP_LOOKUP: begin
				pos = model_bound(it.code, 1'b0);
				if (pos < model_words.size() &&
					(model_words[pos] & mktl_pkg::KEY_MASK) == it.code) begin
					r.found = 1'b1;
					r.scan  = model_words[pos][SCAN_W-1:0];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, int want, int got);
		mismatches++;
		$display("%0t mismatch: %s expected %0h got %0h", $realtime, what, want, got);
	endtask

	task automatic check_result();
		lookup_result_t want;
		if (result_due_q.size() == 0) begin
			report_mismatch("result with nothing pending", 0, 1);
		end else begin
			want = result_due_q.pop_front();
			if (rsp_ch.found !== want.found)
				report_mismatch("found", want.found, rsp_ch.found);
			if (rsp_ch.scan_code !== want.scan)
				report_mismatch("scan_code", want.scan, rsp_ch.scan_code);
			if (rsp_ch.overflow !== want.overflow)
				report_mismatch("overflow", want.overflow, rsp_ch.overflow);
		end
	endtask

	task automatic queue_item(mktl_pkg::op_t op, logic [WORD_W-1:0] word,
		logic [WORD_W-1:0] code);
		table_req_t it;
		it.op   = op;
		it.word = word;
		it.code = code;
		item_backlog = {item_backlog, it};
		if (op == mktl_pkg::OP_CLEAR)
			issued_words.delete();
		else if (op == mktl_pkg::OP_APPEND && issued_words.size() < mktl_pkg::TABLE_DEPTH)
			issued_words = {issued_words, word};
	endtask

	function automatic logic [WORD_W-1:0] pick_issued_key();
		return issued_words[$urandom_range(issued_words.size() - 1)] & mktl_pkg::KEY_MASK;
	endfunction

	// keys from two narrow pools collide often; the rest span the whole word
	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(3))
			0: return (32'($urandom_range(31)) << 9) | 32'($urandom_range(511));
			1: return 32'hFFFF_C000 | 32'($urandom_range(16'h3FFF));
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_random_item();
		int r;
		int s;
		logic [WORD_W-1:0] k;
		r = $urandom_range(99);
		s = $urandom_range(9);
		if (issued_words.size() > 80 || r < 3) begin
			queue_item(mktl_pkg::OP_CLEAR, $urandom, $urandom);
		end else if (r < 6) begin
			queue_item(OP_UNUSED, $urandom, $urandom);
		end else if (r < 46) begin
			if (issued_words.size() == 0 || s < 4)
				k = random_word();
			else if (s < 8)
				k = pick_issued_key() | 32'($urandom_range(511));
			else
				k = issued_words[$urandom_range(issued_words.size() - 1)];
			queue_item(mktl_pkg::OP_APPEND, k, $urandom);
		end else begin
			if (issued_words.size() == 0 || s == 9) begin
				k = (s < 5) ? (random_word() & mktl_pkg::KEY_MASK) : $urandom;
			end else if (s < 6) begin
				k = pick_issued_key();
			end else if (s < 7) begin
				k = pick_issued_key() | 32'($urandom_range(1, 511));
			end else begin
				k = pick_issued_key();
				k = (s == 7) ? k + 32'h200 : k - 32'h200;
			end
			queue_item(mktl_pkg::OP_LOOKUP, $urandom, k);
		end
	endtask

	task automatic wait_drained();
		while (item_backlog.size() != 0 || req_ch.valid || result_due_q.size() != 0) begin
			@(posedge clk);
			#1;
		end
	endtask

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SEND: return $urandom_range(99) < 61;
			IDLE_BOTH: return $urandom_range(99) < 17;
			default:   return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IDLE_RECV: return $urandom_range(99) < 61;
			IDLE_BOTH: return $urandom_range(99) < 17;
			default:   return 1'b0;
		endcase
	endfunction

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (item_backlog.size() != 0 && !sender_idles()) begin
				next_item = item_backlog.pop_front();
				req_ch.valid       <= 1'b1;
				req_ch.operation   <= next_item.op;
				req_ch.entry_word  <= next_item.word;
				req_ch.lookup_code <= next_item.code;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result ready, with one long hold-off in the receiver-stall mode
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (idle_mode == IDLE_RECV && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= !receiver_stalls();
		end
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= req_ch.valid && req_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready)
				check_result();
			if (req_ch.valid && req_ch.ready)
				result_due_q = {result_due_q, model_table_op('{op: req_ch.operation,
					word: req_ch.entry_word, code: req_ch.lookup_code})};
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int i;
		int n;
		logic [WORD_W-1:0] fill_words[$];
		logic [WORD_W-1:0] w;

		clk          = 1'b0;
		arst_n       = 1'b0;
		req_taken    = 1'b0;
		mismatches   = 0;
		quiet_cycles = 0;
		hold_left    = 0;
		hold_done    = 1'b0;
		idle_mode    = IDLE_NONE;
		req_ch.valid       = 1'b0;
		req_ch.operation   = mktl_pkg::OP_CLEAR;
		req_ch.entry_word  = '0;
		req_ch.lookup_code = '0;
		rsp_ch.ready       = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, extremes, duplicates, masked low bits, unused code
		queue_item(mktl_pkg::OP_LOOKUP, 32'h0, 32'h0);
		queue_item(mktl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_item(mktl_pkg::OP_APPEND, 32'h0, 32'h0);
		queue_item(mktl_pkg::OP_APPEND, 32'hFFFF_FFFF, 32'h0);
		queue_item(mktl_pkg::OP_LOOKUP, 32'h0, 32'h0);
		queue_item(mktl_pkg::OP_LOOKUP, 32'h0, 32'hFFFF_FE00);
		queue_item(mktl_pkg::OP_APPEND, DIR_KEY | 32'd5, 32'h0);
		queue_item(mktl_pkg::OP_APPEND, DIR_KEY | 32'd3, 32'h0);
		queue_item(mktl_pkg::OP_APPEND, DIR_KEY | 32'd5, 32'h0);
		queue_item(mktl_pkg::OP_LOOKUP, 32'h0, DIR_KEY);
		queue_item(mktl_pkg::OP_LOOKUP, 32'h0, DIR_KEY | 32'd1);
		queue_item(mktl_pkg::OP_LOOKUP, 32'h0, DIR_KEY + 32'h200);
		queue_item(mktl_pkg::OP_LOOKUP, 32'h0, DIR_KEY - 32'h200);
		queue_item(mktl_pkg::OP_APPEND, 32'hAAAA_AAAA, 32'h5555_5555);
		queue_item(mktl_pkg::OP_LOOKUP, 32'h5555_5555, 32'hAAAA_AA00);
		queue_item(OP_UNUSED, 32'h0, 32'h0);
		queue_item(mktl_pkg::OP_CLEAR, 32'h0, 32'h0);
		queue_item(mktl_pkg::OP_LOOKUP, 32'h0, DIR_KEY);
		queue_item(mktl_pkg::OP_APPEND, 32'h5555_5555, 32'hAAAA_AAAA);
		queue_item(mktl_pkg::OP_LOOKUP, 32'h0, 32'h5555_5400);
		queue_item(mktl_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_drained();

		// descending fill: every word lands at the bottom and moves the whole table up
		for (i = 0; i < FILL_WORDS; i++) begin
			w = (32'(FILL_WORDS - i) << 20) | 32'($urandom_range(20'hF_FFFF));
			fill_words = {fill_words, w};
			queue_item(mktl_pkg::OP_APPEND, w, $urandom);
		end
		queue_item(mktl_pkg::OP_LOOKUP, $urandom, w & mktl_pkg::KEY_MASK);
		queue_item(mktl_pkg::OP_LOOKUP, $urandom, 32'hFFFF_FE00);
		for (i = 0; i < 16; i++) begin
			w = fill_words[$urandom_range(fill_words.size() - 1)];
			queue_item(mktl_pkg::OP_LOOKUP, $urandom,
				(i % 4 == 3) ? w : w & mktl_pkg::KEY_MASK);
		end
		queue_item(mktl_pkg::OP_CLEAR, $urandom, $urandom);
		queue_item(mktl_pkg::OP_LOOKUP, $urandom, w & mktl_pkg::KEY_MASK);
		wait_drained();

		for (n = IDLE_NONE; n <= IDLE_BOTH; n++) begin
			idle_mode = idle_mode_e'(n);
			for (i = 0; i < RAND_PER_MODE; i++)
				queue_random_item();
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (result_due_q.size() != 0)
			report_mismatch("results never delivered", 0, result_due_q.size());
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/mktl_pkg.sv
design/mktl_in_if.sv
design/mktl_out_if.sv
design/mktl_ram.sv
design/masked_key_table_lookup.sv
tb/sv/masked_key_table_lookup_test.sv
